/* rtl/core/rsie_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsie_pkg
// Shared types and codes of the load/store instruction executor.
// ----------------------------------------------------------------------------
package rsie_pkg;

  localparam int unsigned MemWordsDefault = 1024;

  localparam logic [3:0] RegZero = 4'd0;
  localparam logic [3:0] RegLink = 4'd14;
  localparam logic [3:0] RegPc   = 4'd15;

  typedef enum logic [1:0] {
    OP_EXEC = 2'd0,
    OP_WREG = 2'd1,
    OP_WMEM = 2'd2,
    OP_RMEM = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] instr_word;
    logic [3:0]  reg_select;
    logic [31:0] mem_address;
    logic [31:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic [31:0] result_r0;
    logic [2:0]  flags_nzv;
    logic        executed;
    logic [31:0] read_value;
  } out_word_t;

  // Everything the execute stage decides for one item.
  typedef struct packed {
    logic        reg_we;
    logic [3:0]  reg_waddr;
    logic [31:0] reg_wdata;
    logic [31:0] pc_next;
    logic [2:0]  flags_next;
    logic        executed;
    logic        mem_we;
    logic        mem_re;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic        ld_instr;
    logic        ld_byte;
    logic [3:0]  ld_rd;
  } exec_res_t;

endpackage

/* rtl/core/rsie_chan_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsie_chan_if
// Valid/ready channel carrying one word of a packed payload type.
// ----------------------------------------------------------------------------
interface rsie_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/rsie_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsie_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rsie_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read-before-write: a read at the write address returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/rsie_regfile.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsie_regfile
// Register file with three read ports built from RAM copies, valid bits,
// one-entry write forwarding and a mirror of r0.
// ----------------------------------------------------------------------------
module rsie_regfile
  import rsie_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [2:0][3:0]  raddr_i,
  input  logic             we_i,
  input  logic [3:0]       waddr_i,
  input  logic [31:0]      wdata_i,
  input  logic [31:0]      pc_i,
  output logic [2:0][31:0] rdata_o,
  output logic [31:0]      r0_o
);

  logic [2:0][31:0] ram_rdata;
  logic [2:0][3:0]  raddr_q;
  logic [15:0]      valid_q;
  logic             fwd_en_q;
  logic [3:0]       fwd_addr_q;
  logic [31:0]      fwd_data_q;
  logic [31:0]      r0_q;

  for (genvar g = 0; g < 3; g++) begin : g_copy
    rsie_ram #(
      .Width (32),
      .Depth (16)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we_i),
      .waddr_i (waddr_i),
      .wdata_i (wdata_i),
      .re_i    (rd_en_i),
      .raddr_i (raddr_i[g]),
      .rdata_o (ram_rdata[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      fwd_en_q <= 1'b0;
      r0_q     <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
      fwd_en_q         <= 1'b1;
      if (waddr_i == RegZero) begin
        r0_q <= wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      raddr_q <= raddr_i;
    end
    if (we_i) begin
      fwd_addr_q <= waddr_i;
      fwd_data_q <= wdata_i;
    end
  end

  // The counter lives outside the RAM; the last write may not be visible yet.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (raddr_q[i] == RegPc) begin
        rdata_o[i] = pc_i;
      end else if (fwd_en_q && fwd_addr_q == raddr_q[i]) begin
        rdata_o[i] = fwd_data_q;
      end else if (valid_q[raddr_q[i]]) begin
        rdata_o[i] = ram_rdata[i];
      end else begin
        rdata_o[i] = '0;
      end
    end
  end

  assign r0_o = r0_q;

endmodule

/* rtl/core/rsie_exec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsie_exec
// Decode and execute logic for one item, given its resolved operands.
// ----------------------------------------------------------------------------
module rsie_exec
  import rsie_pkg::*;
(
  input  in_word_t    item_i,
  input  logic [31:0] rn_i,
  input  logic [31:0] rm_i,
  input  logic [31:0] rd_i,
  input  logic [31:0] pc_i,
  input  logic [2:0]  flags_i,
  output exec_res_t   res_o
);

  localparam logic [3:0] CondEq = 4'b0000;
  localparam logic [3:0] CondNe = 4'b0001;
  localparam logic [3:0] CondGt = 4'b1100;
  localparam logic [3:0] CondLe = 4'b1101;
  localparam logic [3:0] CondAl = 4'b1110;

  localparam logic [1:0] ClsDp   = 2'd0;
  localparam logic [1:0] ClsMem  = 2'd1;
  localparam logic [1:0] ClsBr   = 2'd2;
  localparam logic [1:0] ClsNone = 2'd3;

  localparam logic [3:0] DpMov = 4'hD;
  localparam logic [3:0] DpAdd = 4'h4;
  localparam logic [3:0] DpSub = 4'h2;
  localparam logic [3:0] DpCmp = 4'hA;
  localparam logic [3:0] DpMvn = 4'hF;
  localparam logic [3:0] DpCmn = 4'hB;

  localparam logic [23:0] BxPattern = 24'h12FFF1;

  logic [31:0] iw;
  logic        flag_n, flag_z, flag_v;
  logic        cond_ok;
  logic        is_bx;
  logic [1:0]  cls;
  logic [3:0]  opc;
  logic [31:0] src;
  logic        negate;
  logic [31:0] opb;
  logic [31:0] sum;
  logic [2:0]  sum_flags;
  logic [31:0] pc_plus4;
  logic [31:0] offset;
  logic [31:0] mem_addr;
  logic [31:0] dp_value;
  logic        dp_writes;

  assign iw       = item_i.instr_word;
  assign flag_n   = flags_i[2];
  assign flag_z   = flags_i[1];
  assign flag_v   = flags_i[0];
  assign is_bx    = (iw[27:4] == BxPattern);
  assign cls      = is_bx ? ClsBr : iw[27:26];
  assign opc      = iw[24:21];
  assign pc_plus4 = pc_i + 32'd4;

  always_comb begin
    case (iw[31:28])
      CondAl:  cond_ok = 1'b1;
      CondEq:  cond_ok = flag_z;
      CondNe:  cond_ok = !flag_z;
      CondGt:  cond_ok = !flag_z && (flag_n == flag_v);
      CondLe:  cond_ok = flag_z || (flag_n != flag_v);
      default: cond_ok = 1'b0;
    endcase
  end

  // One adder serves add, sub, cmp and cmn; subtraction adds the negation.
  assign src       = iw[25] ? {{24{iw[7]}}, iw[7:0]} : rm_i;
  assign negate    = (opc == DpSub) || (opc == DpCmp);
  assign opb       = negate ? (~src + 32'd1) : src;
  assign sum       = rn_i + opb;
  assign sum_flags = {sum[31], (sum == 32'd0),
                      (rn_i[31] == opb[31]) && (sum[31] != rn_i[31])};

  always_comb begin
    dp_writes = 1'b1;
    case (opc)
      DpMov:   dp_value = src;
      DpAdd:   dp_value = sum;
      DpSub:   dp_value = sum;
      DpMvn:   dp_value = ~src;
      default: begin
        dp_value  = sum;
        dp_writes = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (!iw[25]) begin
      offset = {{20{iw[11]}}, iw[11:0]};
    end else if (iw[6:5] == 2'b00) begin
      offset = rm_i << iw[11:7];
    end else begin
      offset = rm_i;
    end
  end

  assign mem_addr = rn_i + offset;

  always_comb begin
    res_o            = '0;
    res_o.pc_next    = pc_i;
    res_o.flags_next = flags_i;
    res_o.mem_addr   = item_i.mem_address;
    res_o.mem_wdata  = item_i.write_value;
    res_o.ld_byte    = iw[22];
    res_o.ld_rd      = iw[15:12];
    case (item_i.op)
      OP_EXEC: begin
        // A zero counter means halted: the instruction is dropped.
        if (pc_i != 32'd0) begin
          if (cond_ok && cls != ClsNone) begin
            res_o.executed = 1'b1;
            case (cls)
              ClsDp: begin
                res_o.pc_next = pc_plus4;
                if (dp_writes) begin
                  if (iw[15:12] == RegPc) begin
                    res_o.pc_next = dp_value + 32'd4;
                  end else begin
                    res_o.reg_we    = 1'b1;
                    res_o.reg_waddr = iw[15:12];
                    res_o.reg_wdata = dp_value;
                  end
                end
                if ((opc == DpCmp || opc == DpCmn) && iw[20]) begin
                  res_o.flags_next = sum_flags;
                end
              end
              ClsMem: begin
                res_o.mem_addr = mem_addr;
                if (iw[20]) begin
                  // Counter moves on when the loaded word is written back.
                  res_o.mem_re   = 1'b1;
                  res_o.ld_instr = 1'b1;
                end else begin
                  res_o.mem_we    = 1'b1;
                  res_o.mem_wdata = rd_i;
                  res_o.pc_next   = pc_plus4;
                end
              end
              default: begin
                if (is_bx) begin
                  res_o.pc_next = rm_i;
                end else begin
                  if (iw[24]) begin
                    res_o.reg_we    = 1'b1;
                    res_o.reg_waddr = RegLink;
                    res_o.reg_wdata = pc_plus4;
                  end
                  res_o.pc_next = pc_i + {{6{iw[23]}}, iw[23:0], 2'b00} + 32'd8;
                end
              end
            endcase
          end else begin
            res_o.pc_next = pc_plus4;
          end
        end
      end
      OP_WREG: begin
        if (item_i.reg_select == RegPc) begin
          res_o.pc_next = item_i.write_value;
        end else begin
          res_o.reg_we    = 1'b1;
          res_o.reg_waddr = item_i.reg_select;
          res_o.reg_wdata = item_i.write_value;
        end
      end
      OP_WMEM: begin
        res_o.mem_we = 1'b1;
      end
      OP_RMEM: begin
        res_o.mem_re = 1'b1;
      end
      default: begin
        res_o.pc_next = pc_i;
      end
    endcase
  end

endmodule

/* rtl/core/risc_subset_instruction_executor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// risc_subset_instruction_executor
// Executes one word of a small load/store instruction set per input word.
// ----------------------------------------------------------------------------
// Each input word either executes the instruction fetched at the reported
// program counter, preloads a register, writes a data memory word or reads
// one back; every input word yields exactly one output word with the new
// counter, the halt status, r0, the N/Z/V flags, whether an instruction took
// effect and any word read. The sixteen registers live in a synchronous RAM
// (kept as three copies for three read ports) with per-register valid bits,
// so reset clears them at once and no clearing pass is needed; r15 is held
// in a flip-flop. An item is read from the register file at the edge where
// it is accepted, then executed and written back once the output register
// is free; its output word is registered. Items follow one per cycle while
// the output is taken: a one-entry forwarding path covers a register
// written by the item just before. Loads (ldr, ldrb) and memory reads
// also pass through the load stage, since the data memory read can only
// start once the address is known, and the input is held off until the
// load writes back. The data memory holds MEM_WORDS words, which must be a
// power of two; it has no reset and must be written before it is read.
// ----------------------------------------------------------------------------
module risc_subset_instruction_executor
  import rsie_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MemWordsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsie_chan_if.sink   in_i,
  rsie_chan_if.source out_o
);

  localparam int unsigned MemAw = $clog2(MEM_WORDS);

  // Execute stage: the accepted word waits here while its register reads
  // come out of the RAM.
  logic      s1_valid_q;
  in_word_t  s1_item_q;

  // Load stage: the data memory read issued by the execute stage.
  logic       ld_q;
  logic       ld_instr_q;
  logic       ld_byte_q;
  logic [1:0] ld_lane_q;
  logic [3:0] ld_rd_q;

  logic        out_valid_q;
  out_word_t   out_word_q;
  out_word_t   out_word_d;
  logic [31:0] pc_q, pc_d;
  logic [2:0]  flags_q, flags_d;

  logic             accept;
  logic             out_free;
  logic             exec_fire;
  logic             ld_fire;
  logic             out_load;
  logic [2:0][3:0]  rf_raddr;
  logic [2:0][31:0] rf_rdata;
  logic             rf_we;
  logic [3:0]       rf_waddr;
  logic [31:0]      rf_wdata;
  logic [31:0]      r0_cur;
  logic [31:0]      r0_next;
  exec_res_t        res;
  logic [31:0]      dmem_rdata;
  logic [31:0]      load_val;

  // Handshake. The output register frees up when it is empty or being taken.
  // A load in the execute stage, or one waiting for the output, holds off
  // the input so that its write-back stays in program order.
  assign out_free  = !out_valid_q || out_o.ready;
  assign exec_fire = s1_valid_q && out_free;
  assign ld_fire   = ld_q && out_free;
  assign in_i.ready = (!s1_valid_q || (exec_fire && !res.mem_re)) && (!ld_q || ld_fire);
  assign accept    = in_i.valid && in_i.ready;

  // Register reads start at acceptance: rn, rm and rd of the instruction.
  assign rf_raddr = {in_i.data.instr_word[15:12], in_i.data.instr_word[3:0],
                     in_i.data.instr_word[19:16]};

  rsie_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (accept),
    .raddr_i (rf_raddr),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .pc_i    (pc_q),
    .rdata_o (rf_rdata),
    .r0_o    (r0_cur)
  );

  rsie_exec u_exec (
    .item_i  (s1_item_q),
    .rn_i    (rf_rdata[0]),
    .rm_i    (rf_rdata[1]),
    .rd_i    (rf_rdata[2]),
    .pc_i    (pc_q),
    .flags_i (flags_q),
    .res_o   (res)
  );

  // Data memory: word accesses drop the low two address bits and wrap.
  rsie_ram #(
    .Width (32),
    .Depth (MEM_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (exec_fire && res.mem_we),
    .waddr_i (res.mem_addr[MemAw+1:2]),
    .wdata_i (res.mem_wdata),
    .re_i    (exec_fire && res.mem_re),
    .raddr_i (res.mem_addr[MemAw+1:2]),
    .rdata_o (dmem_rdata)
  );

  // ldrb picks the byte at its byte address and zero-extends it.
  always_comb begin
    if (ld_byte_q) begin
      case (ld_lane_q)
        2'd0:    load_val = {24'd0, dmem_rdata[7:0]};
        2'd1:    load_val = {24'd0, dmem_rdata[15:8]};
        2'd2:    load_val = {24'd0, dmem_rdata[23:16]};
        default: load_val = {24'd0, dmem_rdata[31:24]};
      endcase
    end else begin
      load_val = dmem_rdata;
    end
  end

  // The single register file write port serves the load stage and the
  // execute stage, which are never busy in the same cycle.
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = res.reg_waddr;
    rf_wdata = res.reg_wdata;
    pc_d     = pc_q;
    flags_d  = flags_q;
    if (ld_fire) begin
      if (ld_instr_q) begin
        rf_waddr = ld_rd_q;
        rf_wdata = load_val;
        if (ld_rd_q == RegPc) begin
          pc_d = load_val + 32'd4;
        end else begin
          rf_we = 1'b1;
          pc_d  = pc_q + 32'd4;
        end
      end
    end else if (exec_fire) begin
      rf_we   = res.reg_we;
      pc_d    = res.pc_next;
      flags_d = res.flags_next;
    end
  end

  assign r0_next  = (rf_we && rf_waddr == RegZero) ? rf_wdata : r0_cur;
  assign out_load = ld_fire || (exec_fire && !res.mem_re);

  always_comb begin
    out_word_d            = '0;
    out_word_d.next_pc    = pc_d;
    out_word_d.halted     = (pc_d == 32'd0);
    out_word_d.result_r0  = r0_next;
    out_word_d.flags_nzv  = flags_d;
    if (ld_fire) begin
      out_word_d.executed   = ld_instr_q;
      out_word_d.read_value = ld_instr_q ? 32'd0 : dmem_rdata;
    end else begin
      out_word_d.executed   = res.executed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      ld_q        <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      flags_q     <= '0;
    end else begin
      pc_q    <= pc_d;
      flags_q <= flags_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (exec_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (exec_fire && res.mem_re) begin
        ld_q <= 1'b1;
      end else if (ld_fire) begin
        ld_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_i.data;
    end
    if (exec_fire && res.mem_re) begin
      ld_instr_q <= res.ld_instr;
      ld_byte_q  <= res.ld_byte;
      ld_lane_q  <= res.mem_addr[1:0];
      ld_rd_q    <= res.ld_rd;
    end
    if (out_load) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

  // The execute and load stages never hold work at the same time.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(s1_valid_q && ld_q))
    else $error("execute and load stages both busy");

  // A memory read leaving the execute stage always lands in the load stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && res.mem_re |=> ld_q)
    else $error("load stage not entered after memory read");

  // No new word enters while a pending load has not written back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!ld_q || ld_fire))
    else $error("word accepted ahead of pending load write-back");

  // The register file RAM never holds the counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> rf_waddr != RegPc)
    else $error("register file write to the counter");

  // A halted core leaves the counter at zero when told to execute.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && s1_item_q.op == OP_EXEC && pc_q == 32'd0 |=> pc_q == 32'd0)
    else $error("counter moved while halted");

endmodule
